// ----- design/fdfp_pkg.sv -----
package fdfp_pkg;

	localparam int MaxFields = 16;

	localparam int ByteW   = 8;
	localparam int ValueW  = 32;
	localparam int IndexW  = 4;
	localparam int FieldW  = 5;
	localparam int CountW  = 5;
	localparam int TdataInW  = 8;
	localparam int TdataOutW = 40;

	localparam logic [ByteW-1:0] ChFrame = 8'h23;
	localparam logic [ByteW-1:0] ChDelim = 8'h3B;
	localparam logic [ByteW-1:0] ChMinus = 8'h2D;
	localparam logic [ByteW-1:0] ChZero  = 8'h30;
	localparam logic [ByteW-1:0] ChNine  = 8'h39;

	localparam logic [ValueW-1:0] MagLimit = 32'h8000_0000;
	localparam logic [ValueW-1:0] PosMax   = 32'h7FFF_FFFF;
	localparam logic [FieldW-1:0] FieldSat = 5'd31;
	localparam logic [CountW-1:0] CountReset = 5'd4;

	typedef struct packed {
		logic              inside_frame;
		logic              frame_has_content;
		logic [ValueW-1:0] magnitude_acc;
		logic              is_negative;
		logic              digits_ended;
		logic [FieldW-1:0] current_field;
		logic              field_started;
	} fdfp_state_t;

	typedef struct packed {
		logic                     valid;
		logic signed [ValueW-1:0] value;
		logic [IndexW-1:0]        field_index;
		logic                     last_of_frame;
	} fdfp_result_t;

	localparam fdfp_state_t StateReset = '{
		inside_frame:      1'b0,
		frame_has_content: 1'b0,
		magnitude_acc:     '0,
		is_negative:       1'b0,
		digits_ended:      1'b0,
		current_field:     '0,
		field_started:     1'b0
	};

endpackage

// ----- design/fdfp_step.sv -----
module fdfp_step
	import fdfp_pkg::*;
(
	input  fdfp_state_t       cur,
	input  logic [ByteW-1:0]  rx_byte,
	input  logic [CountW-1:0] fields_per_frame,
	output fdfp_state_t       nxt,
	output fdfp_result_t      res
);

	logic [CountW-1:0] limit;
	logic [ValueW+3:0] mag_x10;
	logic [ValueW-1:0] mag_sat;
	logic [ValueW-1:0] field_val;
	logic              is_digit;
	logic              emit;
	logic              emit_last;

	always_comb begin
		if (fields_per_frame > CountW'(MaxFields)) begin
			limit = CountW'(MaxFields);
		end else begin
			limit = fields_per_frame;
		end
	end

	// times ten as two shifts and an add, then saturate at 2^31
	assign mag_x10 = {cur.magnitude_acc, 3'b000} + {2'b00, cur.magnitude_acc, 1'b0}
		+ {(ValueW-ByteW+4)'(0), rx_byte - ChZero};
	assign mag_sat = (mag_x10 > {4'b0000, MagLimit}) ? MagLimit : mag_x10[ValueW-1:0];
	assign is_digit = (rx_byte >= ChZero) && (rx_byte <= ChNine);

	always_comb begin
		if (cur.is_negative) begin
			field_val = ValueW'(0) - cur.magnitude_acc;
		end else if (cur.magnitude_acc > PosMax) begin
			field_val = PosMax;
		end else begin
			field_val = cur.magnitude_acc;
		end
	end

	always_comb begin
		nxt       = cur;
		emit      = 1'b0;
		emit_last = 1'b0;
		if (!cur.inside_frame) begin
			if (rx_byte == ChFrame) begin
				nxt = StateReset;
				nxt.inside_frame = 1'b1;
			end
		end else if (rx_byte == ChFrame) begin
			if (cur.frame_has_content) begin
				emit      = 1'b1;
				emit_last = 1'b1;
				nxt       = StateReset;
			end
		end else begin
			nxt.frame_has_content = 1'b1;
			if (rx_byte == ChDelim) begin
				emit = 1'b1;
				nxt.magnitude_acc = '0;
				nxt.is_negative   = 1'b0;
				nxt.digits_ended  = 1'b0;
				nxt.field_started = 1'b0;
				if (cur.current_field < FieldSat) begin
					nxt.current_field = cur.current_field + FieldW'(1);
				end
			end else if (!cur.digits_ended) begin
				nxt.field_started = 1'b1;
				if (is_digit) begin
					nxt.magnitude_acc = mag_sat;
				end else if (rx_byte == ChMinus && !cur.field_started) begin
					nxt.is_negative = 1'b1;
				end else begin
					nxt.digits_ended = 1'b1;
				end
			end
		end
	end

	assign res.valid         = emit && (cur.current_field < limit);
	assign res.value         = field_val;
	assign res.field_index   = cur.current_field[IndexW-1:0];
	assign res.last_of_frame = emit_last;

endmodule

// ----- design/framed_decimal_field_parser.sv -----
// framed decimal field parser
//
// takes one ascii character per slave-side transfer and parses frames of the
// form '#v0;v1;...#'. each field is read as an optional '-' then decimal digits,
// saturated to the 32-bit signed range. a value leaves on the master side at
// every ';' and at the closing '#', which raises tlast. fields at or beyond
// fields_per_frame (clamped to 16) are dropped; bytes outside a frame are ignored
// and a run of '#' at the start opens a single frame.
//
// stages: input register, then parse logic into the result register.
// throughput: one byte per cycle while results are accepted; the only loop is the
// parse state update (multiply by ten and saturate on the field accumulator).
// stalls: while a result sits unaccepted the input register holds and
// s_axis_tready drops only when that register is also full.
// reset: arst_n clears all parse state and both valid flags, and loads
// fields_per_frame with 4. cfg_we writes the count; the user must do this only
// while the block is idle, as the block itself does not enforce it.
module framed_decimal_field_parser
	import fdfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration: fields_per_frame
	input  logic                 cfg_we,
	input  logic [CountW-1:0]    cfg_wdata,
	// slave side
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [TdataInW-1:0]  s_axis_tdata,   // [7:0] rx_byte
	// master side
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [TdataOutW-1:0] m_axis_tdata,   // [31:0] value, [35:32] field_index, zero pad
	output logic                 m_axis_tlast    // last_of_frame
);

	logic [CountW-1:0] fields_per_frame_q;

	// input register
	logic              valid_s1;
	logic [ByteW-1:0]  byte_s1;

	// parse state
	fdfp_state_t       state_q;
	fdfp_state_t       state_nxt;
	fdfp_result_t      res;

	// result register
	logic              valid_s2;
	logic [ValueW-1:0] value_s2;
	logic [IndexW-1:0] index_s2;
	logic              last_s2;

	logic              advance;

	// the byte in the input register is consumed once the result slot is free or is being read out
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_per_frame_q <= CountReset;
		end else if (cfg_we) begin
			fields_per_frame_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata[ByteW-1:0];
		end
	end

	fdfp_step u_step (
		.cur              (state_q),
		.rx_byte          (byte_s1),
		.fields_per_frame (fields_per_frame_q),
		.nxt              (state_nxt),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result slot: refilled when a byte is consumed, emptied on a master transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			value_s2 <= res.value;
			index_s2 <= res.field_index;
			last_s2  <= res.last_of_frame;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(TdataOutW-ValueW-IndexW)'(0), index_s2, value_s2};
	assign m_axis_tlast  = last_s2;

endmodule
